// ===== design/generational_handle_table_defines.svh =====
// Assertion macros used by the checker file of the handle table.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef GENERATIONAL_HANDLE_TABLE_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GHT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("handle table check failed");

// Next-cycle implication, disabled during reset.
`define GHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("handle table check failed");

`endif

// ===== design/ght_pkg.sv =====
// Package of the generational handle table: item types, codes and sizes.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ght_pkg;

    localparam int SLOTS_DEFAULT = 1024;
    localparam int GEN_W = 16;
    localparam int PAY_W = 32;
    localparam int FIELD_IDX_W = 10;

    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_RESOLVE    = 2'd1,
        OP_RELEASE    = 2'd2,
        OP_UNREGISTER = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NULL     = 3'd1,
        ST_FULL     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_STALE    = 3'd4,
        ST_MISMATCH = 3'd5
    } status_t;

    typedef enum logic {
        PH_IDLE = 1'b0,
        PH_EXEC = 1'b1
    } phase_t;

    typedef struct packed {
        opcode_t                  opcode;
        logic [FIELD_IDX_W-1:0]   slot_index;
        logic [GEN_W-1:0]         handle_generation;
        logic [PAY_W-1:0]         payload;
    } req_item_t;

    typedef struct packed {
        status_t                  status;
        logic [FIELD_IDX_W-1:0]   out_index;
        logic [GEN_W-1:0]         out_generation;
        logic [PAY_W-1:0]         out_payload;
        logic [FIELD_IDX_W-1:0]   occupied_count;
    } rsp_item_t;

    typedef struct packed {
        logic rd;
        logic push;
        logic pop;
    } stack_ctrl_t;

endpackage

// ===== design/ght_slot_ram.sv =====
// Slot memory: payload and generation of each slot in one word.
// Registered read; uses ght_pkg for field widths.
`timescale 1ns / 1ps

module ght_slot_ram #(
    parameter int SLOTS = ght_pkg::SLOTS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [$clog2(SLOTS)-1:0]   rd_addr,
    output logic [ght_pkg::PAY_W-1:0]  rd_payload,
    output logic [ght_pkg::GEN_W-1:0]  rd_gen,
    input  logic                       wr_en,
    input  logic [$clog2(SLOTS)-1:0]   wr_addr,
    input  logic [ght_pkg::PAY_W-1:0]  wr_payload,
    input  logic [ght_pkg::GEN_W-1:0]  wr_gen
);

    localparam int WORD_W = ght_pkg::PAY_W + ght_pkg::GEN_W;

    logic [WORD_W-1:0] mem [SLOTS];
    logic [WORD_W-1:0] rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_payload, wr_gen};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign rd_payload = rd_word_reg[WORD_W-1:ght_pkg::GEN_W];
    assign rd_gen     = rd_word_reg[ght_pkg::GEN_W-1:0];

endmodule

// ===== design/ght_free_stack.sv =====
// Free stack of released slots: index with the generation it will carry next.
// Holds the stack pointer and a RAM with a registered read of the top entry.
`timescale 1ns / 1ps

module ght_free_stack #(
    parameter int SLOTS = ght_pkg::SLOTS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ght_pkg::stack_ctrl_t         ctrl,
    input  logic [$clog2(SLOTS)-1:0]     push_index,
    input  logic [ght_pkg::GEN_W-1:0]    push_gen,
    output logic [$clog2(SLOTS)-1:0]     top_index,
    output logic [ght_pkg::GEN_W-1:0]    top_gen,
    output logic                         empty
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int WORD_W = IDX_W + ght_pkg::GEN_W;
    localparam logic [CNT_W-1:0] DEPTH = CNT_W'(SLOTS);
    localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);

    logic [WORD_W-1:0] mem [SLOTS];
    logic [WORD_W-1:0] rd_word_reg;
    logic [CNT_W-1:0]  top_reg;
    logic [CNT_W-1:0]  top_next;
    logic [CNT_W-1:0]  top_minus;
    logic              push_ok;

    assign empty     = (top_reg == '0);
    assign top_minus = top_reg - ONE;
    assign push_ok   = ctrl.push && (top_reg < DEPTH);

    always_comb
    begin
        top_next = top_reg;
        if (push_ok)
        begin
            top_next = top_reg + ONE;
        end
        else if (ctrl.pop && !empty)
        begin
            top_next = top_minus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
        end
        else
        begin
            top_reg <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[top_reg[IDX_W-1:0]] <= {push_index, push_gen};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd && !empty)
        begin
            rd_word_reg <= mem[top_minus[IDX_W-1:0]];
        end
    end

    assign top_index = rd_word_reg[WORD_W-1:ght_pkg::GEN_W];
    assign top_gen   = rd_word_reg[ght_pkg::GEN_W-1:0];

endmodule

// ===== design/generational_handle_table.sv =====
// Each item is accepted in the idle state and finished in the execute state: at
// acceptance the slot RAM is read and, for a register item, the top of the free
// stack RAM; in the next cycle the result is decided, the slot and the stack are
// written back and the result enters the output register. A new item is accepted
// in the cycle after that, while the result may still wait to be taken; if the output
// register is still full when the next item reaches its execute state, that state repeats until it drains.
// No clearing pass is needed after reset: a slot's word is used only once it has
// been issued and written, and a stack entry is read only below the stack pointer.
// Top level of the handle table; depends on ght_pkg, ght_slot_ram, ght_free_stack.
`timescale 1ns / 1ps

module generational_handle_table #(
    parameter int SLOTS = ght_pkg::SLOTS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  ght_pkg::req_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ght_pkg::rsp_item_t  rsp
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int FW    = ght_pkg::FIELD_IDX_W;
    localparam int CMP_W = (CNT_W > FW) ? CNT_W : FW;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);
    localparam logic [CMP_W-1:0] SLOTS_X = CMP_W'(SLOTS);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

    ght_pkg::phase_t     state_reg, state_next;
    ght_pkg::req_item_t  req_reg;
    ght_pkg::rsp_item_t  rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [CNT_W-1:0]    hw_reg, hw_next;
    logic [CNT_W-1:0]    live_reg, live_next;

    logic                accept;
    logic                fire;
    logic [CMP_W-1:0]    in_idx_ext;
    logic [CMP_W-1:0]    idx_ext;
    logic [CMP_W-1:0]    new_idx_ext;

    logic                         slot_rd_en;
    logic [ght_pkg::PAY_W-1:0]    slot_rd_payload;
    logic [ght_pkg::GEN_W-1:0]    slot_rd_gen;
    logic                         slot_wr_en;
    logic [IDX_W-1:0]             slot_wr_addr;
    logic [ght_pkg::PAY_W-1:0]    slot_wr_payload;
    logic [ght_pkg::GEN_W-1:0]    slot_wr_gen;

    ght_pkg::stack_ctrl_t         stack_ctrl;
    logic [IDX_W-1:0]             stack_top_index;
    logic [ght_pkg::GEN_W-1:0]    stack_top_gen;
    logic                         stack_empty;
    logic                         do_push;
    logic                         do_pop;

    logic [IDX_W-1:0]             new_idx;
    logic [ght_pkg::GEN_W-1:0]    new_gen;
    logic                         vacate;

    assign in_idx_ext = CMP_W'(req.slot_index);
    assign idx_ext    = CMP_W'(req_reg.slot_index);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ght_pkg::PH_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ght_pkg::PH_EXEC;
                end
            end
            ght_pkg::PH_EXEC:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ght_pkg::PH_IDLE;
                end
            end
            default:
            begin
                state_next = ght_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        fire      = 1'b0;
        case (state_reg)
            ght_pkg::PH_IDLE:
            begin
                req_ready = 1'b1;
            end
            ght_pkg::PH_EXEC:
            begin
                fire = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign accept     = req_valid && req_ready;
    assign slot_rd_en = accept && (in_idx_ext < SLOTS_X);

    always_comb
    begin
        rsp_next        = '0;
        rsp_next.status = ght_pkg::ST_OK;
        rsp_next.out_index = req_reg.slot_index;
        hw_next         = hw_reg;
        live_next       = live_reg;
        do_pop          = 1'b0;
        vacate          = 1'b0;
        new_idx         = '0;
        new_gen         = '0;
        slot_wr_en      = 1'b0;
        slot_wr_addr    = idx_ext[IDX_W-1:0];
        slot_wr_payload = req_reg.payload;
        slot_wr_gen     = '0;
        new_idx_ext     = '0;

        if (req_reg.opcode == ght_pkg::OP_REGISTER)
        begin
            rsp_next.out_index = '0;
            if (req_reg.payload == '0)
            begin
                rsp_next.status = ght_pkg::ST_NULL;
            end
            else if (!stack_empty || (hw_reg < SLOTS_C))
            begin
                if (!stack_empty)
                begin
                    new_idx = stack_top_index;
                    new_gen = stack_top_gen;
                    do_pop  = 1'b1;
                end
                else
                begin
                    new_idx = hw_reg[IDX_W-1:0];
                    new_gen = '0;
                    hw_next = hw_reg + ONE;
                end
                slot_wr_en      = 1'b1;
                slot_wr_addr    = new_idx;
                slot_wr_gen     = new_gen;
                live_next       = live_reg + ONE;
                new_idx_ext     = CMP_W'(new_idx);
                rsp_next.out_index      = new_idx_ext[FW-1:0];
                rsp_next.out_generation = new_gen;
            end
            else
            begin
                rsp_next.status = ght_pkg::ST_FULL;
            end
        end
        else if (req_reg.slot_index == '0 ||
                 (req_reg.opcode == ght_pkg::OP_UNREGISTER && req_reg.payload == '0))
        begin
            rsp_next.status = ght_pkg::ST_NULL;
        end
        else if (idx_ext >= CMP_W'(hw_reg))
        begin
            rsp_next.status = ght_pkg::ST_RANGE;
        end
        else if (req_reg.opcode == ght_pkg::OP_UNREGISTER)
        begin
            if (slot_rd_payload == '0)
            begin
                rsp_next.status = ght_pkg::ST_STALE;
            end
            else if (slot_rd_payload != req_reg.payload)
            begin
                rsp_next.status = ght_pkg::ST_MISMATCH;
            end
            else
            begin
                vacate = 1'b1;
            end
        end
        else if (slot_rd_payload == '0 || slot_rd_gen != req_reg.handle_generation)
        begin
            rsp_next.status = ght_pkg::ST_STALE;
        end
        else if (req_reg.opcode == ght_pkg::OP_RESOLVE)
        begin
            rsp_next.out_payload = slot_rd_payload;
        end
        else
        begin
            vacate = 1'b1;
        end

        if (vacate)
        begin
            slot_wr_en      = 1'b1;
            slot_wr_payload = '0;
            slot_wr_gen     = slot_rd_gen + ght_pkg::GEN_W'(1);
            if (live_reg != '0)
            begin
                live_next = live_reg - ONE;
            end
        end

        rsp_next.occupied_count = FW'(CMP_W'(live_next));
    end

    assign do_push          = fire && vacate;
    assign stack_ctrl.rd    = accept && (req.opcode == ght_pkg::OP_REGISTER);
    assign stack_ctrl.push  = do_push;
    assign stack_ctrl.pop   = fire && do_pop;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ght_pkg::PH_IDLE;
            rsp_valid_reg <= 1'b0;
            hw_reg        <= ONE;
            live_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (fire)
            begin
                hw_reg   <= hw_next;
                live_reg <= live_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    ght_slot_ram #(
        .SLOTS (SLOTS)
    ) u_slot_ram (
        .clk        (clk),
        .rd_en      (slot_rd_en),
        .rd_addr    (in_idx_ext[IDX_W-1:0]),
        .rd_payload (slot_rd_payload),
        .rd_gen     (slot_rd_gen),
        .wr_en      (fire && slot_wr_en),
        .wr_addr    (slot_wr_addr),
        .wr_payload (slot_wr_payload),
        .wr_gen     (slot_wr_gen)
    );

    ght_free_stack #(
        .SLOTS (SLOTS)
    ) u_free_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (stack_ctrl),
        .push_index (idx_ext[IDX_W-1:0]),
        .push_gen   (slot_wr_gen),
        .top_index  (stack_top_index),
        .top_gen    (stack_top_gen),
        .empty      (stack_empty)
    );

endmodule

// ===== design/ght_checker.sv =====
// Port-level checks of the handle table, attached to the top level by bind.
// Depends on ght_pkg and the macros in generational_handle_table_defines.svh.
`timescale 1ns / 1ps
`include "generational_handle_table_defines.svh"

module ght_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input ght_pkg::req_item_t  req,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input ght_pkg::rsp_item_t  rsp
);

    // A held result keeps its value until it is taken.
    `GHT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // One item at a time: no acceptance in the cycle after an acceptance.
    `GHT_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

    // A failed operation reports neither a generation nor a payload.
    `GHT_ASSERT_SAME(a_fail_clean, rsp_valid && rsp.status != ght_pkg::ST_OK,
        rsp.out_generation == '0 && rsp.out_payload == '0)

    // A full table hands out no index.
    `GHT_ASSERT_SAME(a_full_no_index, rsp_valid && rsp.status == ght_pkg::ST_FULL,
        rsp.out_index == '0)

endmodule

bind generational_handle_table ght_checker u_ght_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ===== tb/sv/generational_handle_table_tb.sv =====
// Self-checking testbench of the generational handle table: directed and random
// register, resolve, release and unregister items checked against a tracked table.
// Depends on ght_pkg and generational_handle_table.
`timescale 1ns / 1ps

module generational_handle_table_tb;

    localparam int SLOTS = ght_pkg::SLOTS_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int AHEAD = 4;
    localparam int STALL_CYCLES = 80;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    ght_pkg::req_item_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    ght_pkg::rsp_item_t rsp;

    ght_pkg::req_item_t pending_q[$];
    ght_pkg::rsp_item_t expected_q[$];

    logic [ght_pkg::PAY_W-1:0] tag_mem [SLOTS];
    logic [ght_pkg::GEN_W-1:0] gen_mem [SLOTS];
    logic [ght_pkg::FIELD_IDX_W-1:0] free_mem [SLOTS];
    int free_cnt = 0;
    int next_fresh = 1;
    int live_cnt = 0;
    int full_hits = 0;

    int errors = 0;
    int cycles = 0;
    bit calm = 1'b0;
    int stall_asks = 0;
    int stall_seen = 0;
    int stall_left = 0;

    generational_handle_table #(
        .SLOTS(SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void free_slot(int idx);
        tag_mem[idx] = '0;
        gen_mem[idx] = gen_mem[idx] + 16'd1;
        free_mem[free_cnt] = idx[ght_pkg::FIELD_IDX_W-1:0];
        free_cnt++;
        if (live_cnt > 0)
            live_cnt--;
    endfunction

    function automatic ght_pkg::rsp_item_t serve_request(ght_pkg::req_item_t r);
        ght_pkg::rsp_item_t o;
        int n;
        int idx;
        o = '0;
        o.status = ght_pkg::ST_OK;
        o.out_index = r.slot_index;
        idx = r.slot_index;
        if (r.opcode == ght_pkg::OP_REGISTER)
        begin
            o.out_index = '0;
            if (r.payload == '0)
                o.status = ght_pkg::ST_NULL;
            else if (free_cnt > 0 || next_fresh < SLOTS)
            begin
                if (free_cnt > 0)
                begin
                    free_cnt--;
                    n = free_mem[free_cnt];
                end
                else
                begin
                    n = next_fresh;
                    next_fresh++;
                    gen_mem[n] = '0;
                end
                tag_mem[n] = r.payload;
                live_cnt++;
                o.out_index = n[ght_pkg::FIELD_IDX_W-1:0];
                o.out_generation = gen_mem[n];
            end
            else
            begin
                o.status = ght_pkg::ST_FULL;
                full_hits++;
            end
        end
        else if (idx == 0 || (r.opcode == ght_pkg::OP_UNREGISTER && r.payload == '0))
            o.status = ght_pkg::ST_NULL;
        else if (idx >= next_fresh)
            o.status = ght_pkg::ST_RANGE;
        else if (r.opcode == ght_pkg::OP_UNREGISTER)
        begin
            if (tag_mem[idx] == '0)
                o.status = ght_pkg::ST_STALE;
            else if (tag_mem[idx] != r.payload)
                o.status = ght_pkg::ST_MISMATCH;
            else
                free_slot(idx);
        end
        else if (tag_mem[idx] == '0 || gen_mem[idx] != r.handle_generation)
            o.status = ght_pkg::ST_STALE;
        else if (r.opcode == ght_pkg::OP_RESOLVE)
            o.out_payload = tag_mem[idx];
        else
            free_slot(idx);
        o.occupied_count = live_cnt[ght_pkg::FIELD_IDX_W-1:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        errors++;
    endtask

    task automatic offer(ght_pkg::opcode_t op, int idx, logic [ght_pkg::GEN_W-1:0] gen,
                         logic [ght_pkg::PAY_W-1:0] pay);
        ght_pkg::req_item_t it;
        it.opcode = op;
        it.slot_index = idx[ght_pkg::FIELD_IDX_W-1:0];
        it.handle_generation = gen;
        it.payload = pay;
        while (pending_q.size() >= AHEAD)
            @(posedge clk);
        pending_q = {pending_q, it};
    endtask

    function automatic bit pick_live(output int idx);
        idx = 0;
        if (next_fresh <= 1)
            return 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            idx = $urandom_range(next_fresh - 1, 1);
            if (tag_mem[idx] != '0)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // An item that is not a register item addresses a handle that is live as far as
    // the table is known; a share of them is then spoiled to hit the error paths.
    task automatic random_item(int reg_pct);
        int idx;
        int pick;
        logic [ght_pkg::PAY_W-1:0] pay;
        logic [ght_pkg::GEN_W-1:0] gen;
        ght_pkg::opcode_t op;
        pay = $urandom;
        if ($urandom_range(49, 0) == 0)
            pay = '1;
        pick = $urandom_range(99, 0);
        if (pick >= reg_pct && pick_live(idx))
        begin
            op = ght_pkg::opcode_t'($urandom_range(3, 1));
            gen = gen_mem[idx];
            if (op == ght_pkg::OP_UNREGISTER)
                pay = tag_mem[idx];
            case ($urandom_range(19, 0))
                0: idx = 0;
                1: idx = $urandom_range(1023, 1);
                2: gen = gen ^ (16'd1 << $urandom_range(15, 0));
                3: gen = ght_pkg::GEN_W'($urandom);
                4: pay = $urandom;
                5: pay = '0;
                default: ;
            endcase
            offer(op, idx, gen, pay);
        end
        else
        begin
            if ($urandom_range(24, 0) == 0)
                pay = '0;
            else if (pay == '0)
                pay = 32'd1;
            offer(ght_pkg::OP_REGISTER, $urandom_range(1023, 0),
                  ght_pkg::GEN_W'($urandom), pay);
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || req_valid || expected_q.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        bit took;
        took = rst_n && req_valid && req_ready;
        if (took)
            expected_q = {expected_q, serve_request(req)};
        @(negedge clk);
        if (rst_n && (took || !req_valid))
        begin
            if (pending_q.size() > 0 && (calm || $urandom_range(99, 0) >= 14))
            begin
                req <= pending_q.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        ght_pkg::rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("result with no pending item, payload", rsp.out_payload, 0);
            else
            begin
                want = expected_q.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", rsp.status, want.status);
                if (rsp.out_index !== want.out_index)
                    report_mismatch("out_index", rsp.out_index, want.out_index);
                if (rsp.out_generation !== want.out_generation)
                    report_mismatch("out_generation", rsp.out_generation, want.out_generation);
                if (rsp.out_payload !== want.out_payload)
                    report_mismatch("out_payload", rsp.out_payload, want.out_payload);
                if (rsp.occupied_count !== want.occupied_count)
                    report_mismatch("occupied_count", rsp.occupied_count, want.occupied_count);
            end
        end
        @(negedge clk);
        if (stall_seen != stall_asks)
        begin
            stall_seen = stall_asks;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= rst_n && (calm || $urandom_range(99, 0) >= 14);
    end

    initial
    begin
        int n;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        offer(ght_pkg::OP_REGISTER, 0, 16'h0000, 32'h0000_0000);
        offer(ght_pkg::OP_RESOLVE, 0, 16'h0000, 32'h1111_1111);
        offer(ght_pkg::OP_RELEASE, 0, 16'hFFFF, 32'h0000_0000);
        offer(ght_pkg::OP_UNREGISTER, 5, 16'h0000, 32'h0000_0000);
        offer(ght_pkg::OP_RESOLVE, 1, 16'h0000, 32'h0000_0000);
        offer(ght_pkg::OP_RESOLVE, 1023, 16'hFFFF, 32'hFFFF_FFFF);
        offer(ght_pkg::OP_REGISTER, 1023, 16'hFFFF, 32'hFFFF_FFFF);
        offer(ght_pkg::OP_REGISTER, 0, 16'h0000, 32'h0000_0001);
        offer(ght_pkg::OP_REGISTER, 512, 16'h8000, 32'hA5A5_5A5A);
        offer(ght_pkg::OP_RESOLVE, 1, 16'h0000, 32'h0000_0000);
        offer(ght_pkg::OP_RESOLVE, 1, 16'hFFFF, 32'h0000_0000);
        offer(ght_pkg::OP_RELEASE, 2, 16'h0001, 32'h0000_0000);
        offer(ght_pkg::OP_RELEASE, 2, 16'h0000, 32'h0000_0000);
        offer(ght_pkg::OP_RESOLVE, 2, 16'h0000, 32'h0000_0000);
        offer(ght_pkg::OP_UNREGISTER, 2, 16'h0000, 32'h0000_0001);
        offer(ght_pkg::OP_UNREGISTER, 3, 16'h0000, 32'h0000_1234);
        offer(ght_pkg::OP_UNREGISTER, 3, 16'h0000, 32'hA5A5_5A5A);
        offer(ght_pkg::OP_REGISTER, 0, 16'h0000, 32'h5555_5555);
        offer(ght_pkg::OP_REGISTER, 0, 16'h0000, 32'h0000_2222);
        offer(ght_pkg::OP_REGISTER, 0, 16'h0000, 32'h8000_0000);
        offer(ght_pkg::OP_RESOLVE, 3, 16'h0001, 32'h0000_0000);
        offer(ght_pkg::OP_RELEASE, 1, 16'h0000, 32'h0000_0000);
        offer(ght_pkg::OP_RELEASE, 1, 16'h0000, 32'h0000_0000);
        offer(ght_pkg::OP_RESOLVE, 4, 16'h0000, 32'h0000_0000);
        offer(ght_pkg::OP_UNREGISTER, 4, 16'h0000, 32'h8000_0000);

        calm = 1'b1;
        for (int i = 0; i < 70; i++)
        begin
            if (i == 45)
                calm = 1'b0;
            if (i == 55)
                stall_asks++;
            random_item(60);
        end
        wait_drained();

        // Grow the table until it has reported full 12 times, or for at most 2500 items.
        n = 0;
        while (full_hits < 12 && n < 2500)
        begin
            random_item(98);
            n++;
        end

        for (int i = 0; i < 25; i++)
            random_item(20);
        wait_drained();
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/ght_pkg.sv
design/ght_slot_ram.sv
design/ght_free_stack.sv
design/generational_handle_table.sv
design/ght_checker.sv
tb/sv/generational_handle_table_tb.sv
